// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  // request kinds (in_tuser)
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_NOP     = 2'd3;

  // result status codes (out_tuser)
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_BADFREE  = 2'd2;
  localparam logic [1:0] ST_RELEASED = 2'd3;

  // configuration register indexes
  localparam logic CFG_BSL = 1'b0;
  localparam logic CFG_PO  = 1'b1;

  localparam logic [4:0] BSL_RST = 5'd7;
  localparam logic [3:0] PO_RST  = 4'd8;
  localparam logic [4:0] BSL_MIN = 5'd4;
  localparam logic [4:0] BSL_MAX = 5'd20;

  localparam logic [27:0] HEADER_BYTES = 28'd13;

  localparam int unsigned FIELD_W = 28;
  localparam int unsigned ORD_W   = 4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       acc;
    logic       clr_step;
    logic       kill;
    logic       set_st;
    logic [1:0] st;
    logic       k_clr;
    logic       k_inc;
    logic       scan_init;
    logic       scan_next;
    logic       hit;
    logic       split;
    logic       mark;
    logic       faddr;
    logic       fchk_ok;
    logic       rd_buddy;
    logic       merge;
    logic       settle;
    logic       load_out;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_done;
    logic live;
    logic size_fit;
    logic k_over;
    logic node_free;
    logic last_in_depth;
    logic d_zero;
    logic split_more;
    logic free_bad;
    logic blk_ok;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/buddy_block_allocator.sv =====
// Binary buddy allocator over 2^pool_order basic blocks of 2^block_size_log2
// bytes. in_tuser carries the request kind: allocate (in_tdata request_bytes),
// free (in_tdata payload_offset), release or no-op. Each request gives one result:
// out_tdata holds the granted payload offset (block base plus a 13-byte
// header, zero unless an allocate succeeds) and out_tuser the status (ok, no
// space, bad free address, released). An allocate takes the lowest-address
// free block of the smallest sufficient order and splits it down. A free
// merges buddies upward. Step by step, an allocate sizes the request, probes
// free-tree nodes (the scan of one node-RAM read port, deepest level first),
// splits one level at a time, then marks the block and answers; a free checks
// the address, reads the block table, then merges one level at a time while
// the buddy is free (a bad address answers early); release goes straight to
// the answer. The result sits in an output register, so a new request is taken
// while it waits. After reset and after every configuration write the free
// tree is cleared, one node per cycle, with in_tready low.
module buddy_block_allocator #(
  parameter int unsigned POOL_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_wdata,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [27:0] request_bytes, [55:28] payload_offset
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [27:0] granted_offset, [31:28] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;
  logic [27:0]   granted;

  // sequence the request through search, split, merge and response
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold config, free tree, block table and the result register
  bba_dp #(.POOL_BLOCKS(POOL_BLOCKS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_request_bytes   (in_tdata[27:0]),
    .in_payload_offset  (in_tdata[55:28]),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_granted_offset (granted),
    .out_status         (out_tuser),
    .cmd                (cmd),
    .sts                (sts)
  );

  assign out_tdata = {4'b0, granted};

  // a failed result never carries an offset
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != bba_pkg::ST_OK) |-> out_tdata == 32'd0)
    else $error("offset on failed result");

  // no request is taken in the cycle of a configuration write
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_tready)
    else $error("request taken during config write");

  // one request at a time: ready drops after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

endmodule

// ===== rtl/bba_ram.sv =====
module bba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bba_ctrl.sv =====
module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          in_tvalid,
  input  logic [1:0]    in_kind,
  output logic          in_tready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SIZE     = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_SPLIT    = 4'd5;
  localparam logic [3:0] S_MARK     = 4'd6;
  localparam logic [3:0] S_FADDR    = 4'd7;
  localparam logic [3:0] S_FREAD    = 4'd8;
  localparam logic [3:0] S_FCHK     = 4'd9;
  localparam logic [3:0] S_MREAD    = 4'd10;
  localparam logic [3:0] S_MCHK     = 4'd11;
  localparam logic [3:0] S_RESP     = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE) && !cfg_we;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.acc = 1'b1;
          priority if (in_kind == bba_pkg::KIND_ALLOC) begin
            if (!sts.live) begin
              cmd.set_st = 1'b1;
              cmd.st     = bba_pkg::ST_RELEASED;
              state_nxt  = S_RESP;
            end else begin
              cmd.k_clr = 1'b1;
              state_nxt = S_SIZE;
            end
          end else if (in_kind == bba_pkg::KIND_FREE) begin
            if (!sts.live) begin
              cmd.set_st = 1'b1;
              cmd.st     = bba_pkg::ST_RELEASED;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_FADDR;
            end
          end else begin
            cmd.kill   = (in_kind == bba_pkg::KIND_RELEASE);
            cmd.set_st = 1'b1;
            cmd.st     = bba_pkg::ST_OK;
            state_nxt  = S_RESP;
          end
        end
      end
      S_SIZE: begin
        priority if (sts.k_over) begin
          cmd.set_st = 1'b1;
          cmd.st     = bba_pkg::ST_NOSPACE;
          state_nxt  = S_RESP;
        end else if (sts.size_fit) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN_RD;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        priority if (sts.node_free) begin
          cmd.hit   = 1'b1;
          state_nxt = S_SPLIT;
        end else if (sts.last_in_depth && sts.d_zero) begin
          cmd.set_st = 1'b1;
          cmd.st     = bba_pkg::ST_NOSPACE;
          state_nxt  = S_RESP;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SPLIT: begin
        if (sts.split_more) cmd.split = 1'b1;
        else state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        cmd.set_st = 1'b1;
        cmd.st     = bba_pkg::ST_OK;
        state_nxt  = S_RESP;
      end
      S_FADDR: begin
        cmd.faddr = 1'b1;
        if (sts.free_bad) begin
          cmd.set_st = 1'b1;
          cmd.st     = bba_pkg::ST_BADFREE;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_FREAD;
        end
      end
      S_FREAD: state_nxt = S_FCHK;
      S_FCHK: begin
        if (sts.blk_ok) begin
          cmd.fchk_ok = 1'b1;
          state_nxt   = S_MREAD;
        end else begin
          cmd.set_st = 1'b1;
          cmd.st     = bba_pkg::ST_BADFREE;
          state_nxt  = S_RESP;
        end
      end
      S_MREAD: begin
        if (sts.d_zero) begin
          cmd.settle = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st     = bba_pkg::ST_OK;
          state_nxt  = S_RESP;
        end else begin
          cmd.rd_buddy = 1'b1;
          state_nxt    = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts.node_free) begin
          cmd.merge = 1'b1;
          state_nxt = S_MREAD;
        end else begin
          cmd.settle = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st     = bba_pkg::ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_we) state_nxt = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/bba_dp.sv =====
module bba_dp #(
  parameter int unsigned POOL_BLOCKS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [4:0]           cfg_wdata,
  input  logic [27:0]          in_request_bytes,
  input  logic [27:0]          in_payload_offset,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [27:0]          out_granted_offset,
  output logic [1:0]           out_status,
  input  bba_pkg::cmd_t        cmd,
  output bba_pkg::sts_t        sts
);

  localparam int unsigned LOG_MAX = $clog2(POOL_BLOCKS + 1) - 1;
  localparam int unsigned NODES   = 2 * POOL_BLOCKS - 1;
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned BLK_W   = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int unsigned BM_W    = bba_pkg::ORD_W + 1;

  logic [4:0]        bsl_r;
  logic [3:0]        po_r;
  logic              live_r;
  logic [27:0]       req_r, poff_r;
  logic [4:0]        k_r;
  logic [3:0]        d_r, dt_r, dh_r;
  logic [NODE_W-1:0] n_r, cnt_r;
  logic [BLK_W-1:0]  p_r, blk_r;
  logic [1:0]        st_r;
  logic [27:0]       off_r;
  logic              out_valid_r;
  logic [27:0]       out_off_r;
  logic [1:0]        out_st_r;

  logic [4:0]        bsl_eff;
  logic [3:0]        po_eff;
  logic [28:0]       need;
  logic [5:0]        shamt;
  logic [3:0]        dt;
  logic [NODE_W-1:0] buddy, parent, depth_first, depth_last, n_free;
  logic [3:0]        ord;
  logic              in_use;
  logic [BLK_W-1:0]  blk_alloc;
  logic [36:0]       base;
  logic [27:0]       b, blk_full;

  logic              node_we, node_wd, node_rd;
  logic [NODE_W-1:0] node_wa, node_ra;
  logic              bm_we;
  logic [BLK_W-1:0]  bm_wa;
  logic [BM_W-1:0]   bm_wd, bm_rd;

  assign bsl_eff = (bsl_r < bba_pkg::BSL_MIN) ? bba_pkg::BSL_MIN :
                   (bsl_r > bba_pkg::BSL_MAX) ? bba_pkg::BSL_MAX : bsl_r;
  assign po_eff  = (int'(po_r) > int'(LOG_MAX)) ? 4'(LOG_MAX) : po_r;

  assign need  = {1'b0, req_r} + 29'(bba_pkg::HEADER_BYTES);
  assign shamt = {1'b0, bsl_eff} + {1'b0, k_r};
  assign dt    = po_eff - k_r[3:0];

  assign buddy       = n_r[0] ? n_r + NODE_W'(1) : n_r - NODE_W'(1);
  assign parent      = (n_r - NODE_W'(1)) >> 1;
  assign depth_first = (NODE_W'(1) << d_r) - NODE_W'(1);
  assign depth_last  = (NODE_W'(1) << ({1'b0, d_r} + 5'd1)) - NODE_W'(2);

  assign {in_use, ord} = bm_rd;
  assign n_free = ((NODE_W'(1) << (po_eff - ord)) - NODE_W'(1)) + NODE_W'(blk_r >> ord);

  assign blk_alloc = p_r << (po_eff - dh_r);
  assign base      = 37'(blk_alloc) << bsl_eff;

  assign b        = poff_r - bba_pkg::HEADER_BYTES;
  assign blk_full = b >> bsl_eff;

  // status toward the controller
  always_comb begin
    sts.clr_done      = (cnt_r == NODE_W'(NODES - 1));
    sts.live          = live_r;
    sts.size_fit      = (shamt >= 6'd29) || ((30'(1) << shamt) >= {1'b0, need});
    sts.k_over        = (k_r > {1'b0, po_eff});
    sts.node_free     = node_rd;
    sts.last_in_depth = (n_r == depth_last);
    sts.d_zero        = (d_r == 4'd0);
    sts.split_more    = (d_r < dt_r);
    sts.free_bad      = (poff_r < bba_pkg::HEADER_BYTES) ||
                        ((b & ((28'(1) << bsl_eff) - 28'd1)) != 28'd0) ||
                        ((blk_full >> po_eff) != 28'd0);
    sts.blk_ok        = in_use && (ord <= po_eff) &&
                        ((blk_r & ((BLK_W'(1) << ord) - BLK_W'(1))) == '0);
    sts.out_free      = !out_valid_r || out_tready;
  end

  // node tree write port
  always_comb begin
    node_we = cmd.clr_step | cmd.hit | cmd.split | cmd.merge | cmd.settle;
    node_wa = n_r;
    node_wd = 1'b0;
    priority if (cmd.clr_step) begin
      node_wa = cnt_r;
      node_wd = (cnt_r == '0);
    end else if (cmd.split) begin
      node_wa = (n_r << 1) + NODE_W'(2);
      node_wd = 1'b1;
    end else if (cmd.merge) begin
      node_wa = buddy;
    end else if (cmd.settle) begin
      node_wd = 1'b1;
    end else begin
      node_wd = 1'b0;
    end
  end

  assign node_ra = cmd.rd_buddy ? buddy : n_r;

  // block table write port: in-use bit over order
  always_comb begin
    bm_we = 1'b0;
    bm_wa = blk_r;
    bm_wd = '0;
    priority if (cmd.clr_step) begin
      bm_we = (cnt_r < NODE_W'(POOL_BLOCKS));
      bm_wa = BLK_W'(cnt_r);
    end else if (cmd.mark) begin
      bm_we = 1'b1;
      bm_wa = blk_alloc;
      bm_wd = {1'b1, k_r[3:0]};
    end else if (cmd.fchk_ok) begin
      bm_we = 1'b1;
      bm_wd = {1'b0, ord};
    end else begin
      bm_we = 1'b0;
    end
  end

  bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_wa),
    .wdata (node_wd),
    .raddr (node_ra),
    .rdata (node_rd)
  );

  bba_ram #(.WIDTH(BM_W), .DEPTH(POOL_BLOCKS)) u_blk_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_wa),
    .wdata (bm_wd),
    .raddr (blk_r),
    .rdata (bm_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsl_r       <= bba_pkg::BSL_RST;
      po_r        <= bba_pkg::PO_RST;
      live_r      <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cnt_r <= '0;
        if (cfg_addr == bba_pkg::CFG_BSL) bsl_r <= cfg_wdata;
        else po_r <= cfg_wdata[3:0];
      end else if (cmd.clr_step && !sts.clr_done) begin
        cnt_r <= cnt_r + NODE_W'(1);
      end
      if (cmd.kill) live_r <= 1'b0;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      req_r  <= in_request_bytes;
      poff_r <= in_payload_offset;
      off_r  <= '0;
    end
    if (cmd.set_st) st_r <= cmd.st;
    if (cmd.k_clr) k_r <= '0;
    else if (cmd.k_inc) k_r <= k_r + 5'd1;
    else if (cmd.fchk_ok) k_r <= {1'b0, ord};
    if (cmd.scan_init) begin
      d_r  <= dt;
      dt_r <= dt;
      n_r  <= (NODE_W'(1) << dt) - NODE_W'(1);
    end else if (cmd.scan_next) begin
      if (sts.last_in_depth) begin
        d_r <= d_r - 4'd1;
        n_r <= (NODE_W'(1) << (d_r - 4'd1)) - NODE_W'(1);
      end else begin
        n_r <= n_r + NODE_W'(1);
      end
    end else if (cmd.hit) begin
      dh_r <= d_r;
      p_r  <= BLK_W'(n_r - depth_first);
    end else if (cmd.split) begin
      n_r <= (n_r << 1) + NODE_W'(1);
      d_r <= d_r + 4'd1;
    end else if (cmd.fchk_ok) begin
      d_r <= po_eff - ord;
      n_r <= n_free;
    end else if (cmd.merge) begin
      n_r <= parent;
      d_r <= d_r - 4'd1;
    end
    if (cmd.faddr) blk_r <= BLK_W'(blk_full);
    if (cmd.mark) off_r <= base[27:0] + bba_pkg::HEADER_BYTES;
    if (cmd.load_out) begin
      out_off_r <= off_r;
      out_st_r  <= st_r;
    end
  end

  assign out_tvalid         = out_valid_r;
  assign out_granted_offset = out_off_r;
  assign out_status         = out_st_r;

endmodule

// ===== test/bba_checker.sv =====
module bba_checker #(
  parameter int unsigned POOL_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending,
  output int          results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES  = 2 * POOL_BLOCKS - 1;
  localparam int unsigned MAXLOG = $clog2(POOL_BLOCKS + 1) - 1;

  typedef struct packed {
    logic [27:0] offset;
    logic [1:0]  status;
  } grant_t;

  bit          tree_free [NODES];
  logic [3:0]  run_order [POOL_BLOCKS];
  bit          owned [POOL_BLOCKS];
  bit          accepting;
  logic [4:0]  size_log2;
  logic [3:0]  pool_log2;
  grant_t      grants_due[$];

  function automatic int unsigned size_eff();
    if (size_log2 < bba_pkg::BSL_MIN) return bba_pkg::BSL_MIN;
    if (size_log2 > bba_pkg::BSL_MAX) return bba_pkg::BSL_MAX;
    return size_log2;
  endfunction

  function automatic int unsigned pool_eff();
    return (pool_log2 > MAXLOG) ? MAXLOG : pool_log2;
  endfunction

  function automatic void wipe_tree();
    foreach (tree_free[i]) tree_free[i] = 0;
    foreach (owned[i]) owned[i] = 0;
    tree_free[0] = 1;
  endfunction

  function automatic logic [1:0] carve(input longint unsigned len,
                                       output longint unsigned off);
    int unsigned bsl, po, k, dt, dd;
    longint unsigned need, n, p, blk;
    bsl = size_eff();
    po = pool_eff();
    need = len + bba_pkg::HEADER_BYTES;
    k = 0;
    off = 0;
    while (k <= po && (64'd1 << (bsl + k)) < need) k++;
    if (k > po) return bba_pkg::ST_NOSPACE;
    dt = po - k;
    for (int d = dt; d >= 0; d--) begin
      for (longint unsigned q = 0; q < (64'd1 << d); q++) begin
        n = (64'd1 << d) - 1 + q;
        if (n >= NODES || !tree_free[n]) continue;
        p = q;
        dd = d;
        tree_free[n] = 0;
        // split down, keeping the lower half
        while (dd < dt) begin
          if (2 * n + 2 < NODES) tree_free[2 * n + 2] = 1;
          n = 2 * n + 1;
          p = 2 * p;
          dd++;
        end
        blk = p << k;
        if (blk >= POOL_BLOCKS) return bba_pkg::ST_NOSPACE;
        owned[blk] = 1;
        run_order[blk] = k[3:0];
        off = (blk << bsl) + bba_pkg::HEADER_BYTES;
        return bba_pkg::ST_OK;
      end
    end
    return bba_pkg::ST_NOSPACE;
  endfunction

  function automatic logic [1:0] give_back(input longint unsigned off);
    int unsigned bsl, po, k, d;
    longint unsigned b, blk, n, buddy;
    bsl = size_eff();
    po = pool_eff();
    if (off < bba_pkg::HEADER_BYTES) return bba_pkg::ST_BADFREE;
    b = off - bba_pkg::HEADER_BYTES;
    if ((b & ((64'd1 << bsl) - 1)) != 0) return bba_pkg::ST_BADFREE;
    blk = b >> bsl;
    if (blk >= (64'd1 << po) || blk >= POOL_BLOCKS) return bba_pkg::ST_BADFREE;
    if (!owned[blk]) return bba_pkg::ST_BADFREE;
    k = run_order[blk];
    if (k > po || (blk & ((64'd1 << k) - 1)) != 0) return bba_pkg::ST_BADFREE;
    owned[blk] = 0;
    d = po - k;
    n = (64'd1 << d) - 1 + (blk >> k);
    if (n >= NODES) return bba_pkg::ST_BADFREE;
    tree_free[n] = 1;
    // merge upward while the buddy is free too
    while (d > 0) begin
      buddy = n[0] ? n + 1 : n - 1;
      if (buddy >= NODES || !tree_free[buddy]) break;
      tree_free[n] = 0;
      tree_free[buddy] = 0;
      n = (n - 1) / 2;
      tree_free[n] = 1;
      d--;
    end
    return bba_pkg::ST_OK;
  endfunction

  function automatic grant_t serve(input logic [1:0] kind, input logic [55:0] data);
    grant_t g;
    longint unsigned off;
    g = '0;
    off = 0;
    unique case (kind)
      bba_pkg::KIND_ALLOC: begin
        if (!accepting) g.status = bba_pkg::ST_RELEASED;
        else g.status = carve(data[27:0], off);
        if (g.status == bba_pkg::ST_OK) g.offset = off[27:0];
      end
      bba_pkg::KIND_FREE:
        g.status = accepting ? give_back(data[55:28]) : bba_pkg::ST_RELEASED;
      bba_pkg::KIND_RELEASE: accepting = 0;
      default: ;
    endcase
    return g;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      size_log2 = bba_pkg::BSL_RST;
      pool_log2 = bba_pkg::PO_RST;
      accepting = 1;
      wipe_tree();
      grants_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == bba_pkg::CFG_BSL) size_log2 = cfg_wdata;
        else pool_log2 = cfg_wdata[3:0];
        wipe_tree();
      end
      if (out_tvalid && out_tready) begin
        results++;
        if (grants_due.size() == 0) begin
          report("unexpected result", {out_tuser, out_tdata[29:0]}, '0);
        end else begin
          want = grants_due.pop_front();
          if (out_tdata !== {4'd0, want.offset})
            report("granted_offset", out_tdata, {4'd0, want.offset});
          if (out_tuser !== want.status)
            report("status", 32'(out_tuser), 32'(want.status));
        end
      end
      if (in_tvalid && in_tready) grants_due.push_back(serve(in_tuser, in_tdata));
    end
    pending = grants_due.size();
  end

  final begin
    if (grants_due.size() != 0)
      $display("%0d expected results never arrived", grants_due.size());
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic        cfg_addr = 0;
  logic [4:0]  cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  int fail_count, pending, results;
  int send_idle = 0;   // percent of cycles the request side holds off
  int recv_idle = 0;   // percent of cycles the result side stalls
  int sent = 0;
  int settings = 1;
  int unsigned bsl_now = 7, po_now = 8;
  logic [27:0] live_grants[$];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  buddy_block_allocator dut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  bba_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending, .results
  );

  // Stall the result side at random.
  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle);

  // Remember granted offsets so later frees can name live blocks.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tuser == bba_pkg::ST_OK &&
        out_tdata != 0)
      live_grants.push_back(out_tdata[27:0]);
  end

  // One request transfer; hold valid until the block takes it.
  task automatic send(input logic [1:0] kind, input logic [27:0] req,
                      input logic [27:0] off);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {off, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers once the block is idle; the pool restarts empty.
  task automatic set_pool(input logic [4:0] bsl, input logic [4:0] po);
    drain();
    while (!in_tready) @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= bba_pkg::CFG_BSL;
    cfg_wdata <= bsl;
    @(posedge clk);
    cfg_addr <= bba_pkg::CFG_PO;
    cfg_wdata <= po;
    @(posedge clk);
    cfg_we <= 0;
    bsl_now = (bsl < bba_pkg::BSL_MIN) ? bba_pkg::BSL_MIN :
              (bsl > bba_pkg::BSL_MAX) ? bba_pkg::BSL_MAX : bsl;
    po_now = (po[3:0] > 8) ? 8 : po[3:0];
    live_grants.delete();
    settings++;
  endtask

  // Mostly well-formed alloc/free traffic, with some broken frees and noise.
  task automatic random_request();
    int unsigned r, j, idx;
    logic [27:0] len, off;
    r = $urandom_range(0, 99);
    len = 28'($urandom());
    off = 28'($urandom());
    if (r < 85 && r >= 45 && live_grants.size() != 0) begin
      idx = $urandom_range(0, live_grants.size() - 1);
      off = live_grants[idx];
      // leave a few in the list so they come back as double frees
      if ($urandom_range(0, 9) != 0) live_grants.delete(idx);
      send(bba_pkg::KIND_FREE, len, off);
    end else if (r < 85) begin
      j = $urandom_range(0, po_now);
      if ($urandom_range(0, 9) != 0)
        len = 28'($urandom_range(0, (32'd1 << (bsl_now + j)) - 1));
      send(bba_pkg::KIND_ALLOC, len, off);
    end else if (r < 95) begin
      case ($urandom_range(0, 2))
        0: off = 28'($urandom_range(0, 12));
        1: if (live_grants.size() != 0)
             off = 28'(live_grants[0] + $urandom_range(1, 40));
        default: ;
      endcase
      send(bba_pkg::KIND_FREE, len, off);
    end else begin
      send(bba_pkg::KIND_NOP, len, off);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // Directed: default pool of 256 blocks of 128 bytes.
    send(bba_pkg::KIND_ALLOC, 28'd0, 28'd0);
    send(bba_pkg::KIND_ALLOC, 28'hFFF_FFFF, 28'd0);
    send(bba_pkg::KIND_ALLOC, 28'd115, 28'd0);
    send(bba_pkg::KIND_ALLOC, 28'd116, 28'd0);
    send(bba_pkg::KIND_ALLOC, 28'd32755, 28'd0);
    send(bba_pkg::KIND_ALLOC, 28'd32756, 28'd0);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd0);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd12);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd14);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd32781);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd25613);
    send(bba_pkg::KIND_FREE, 28'd0, 28'hFFF_FFFF);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd13);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd13);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd141);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd269);
    send(bba_pkg::KIND_NOP, 28'hFFF_FFFF, 28'hFFF_FFFF);
    send(bba_pkg::KIND_ALLOC, 28'd32755, 28'd0);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd13);

    // Random phases over a range of pool settings, the extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_pool(5'd4, 5'd3);
        2: set_pool(5'd20, 5'd8);
        3: set_pool(5'd0, 5'd15);
        4: set_pool(5'd31, 5'd0);
        5: set_pool(5'd9, 5'd5);
        default: ;
      endcase
      if (ph < 2) begin
        send_idle = 25;
        recv_idle = 72;
      end else if (ph < 4) begin
        send_idle = 72;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (200) random_request();
    end

    // Release, then allocates and frees are refused; release and no-op still answer ok.
    send(bba_pkg::KIND_RELEASE, 28'd0, 28'd0);
    send(bba_pkg::KIND_ALLOC, 28'd0, 28'd0);
    send(bba_pkg::KIND_FREE, 28'd0, 28'd13);
    send(bba_pkg::KIND_RELEASE, 28'hFFF_FFFF, 28'hFFF_FFFF);
    send(bba_pkg::KIND_NOP, 28'd0, 28'd0);

    drain();
    $display("Covered %0d requests and %0d results over %0d pool settings.",
             sent, results, settings);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #240_000_000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/buddy_block_allocator.sv
test/bba_checker.sv
test/tb_top.sv
